// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while arst_n is high.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(trig) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/n2a_pkg.sv -----
package n2a_pkg;

	typedef enum logic [2:0] {
		OP_DEC32  = 3'd0,
		OP_HEX32  = 3'd1,
		OP_HEX64  = 3'd2,
		OP_BIN8   = 3'd3,
		OP_BIN16  = 3'd4,
		OP_BIN32  = 3'd5
	} op_t;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_UPA  = 8'h41;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_DOT  = 8'h2e;

	localparam logic [3:0] NIB_MASK  = 4'hf;
	localparam logic [3:0] DEC_RADIX = 4'd10;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip;
		logic emit;
	} n2a_cmd_t;

	typedef struct packed {
		logic in_dec;
		logic in_valid;
		logic conv_last;
		logic lead_zero;
		logic last_char;
	} n2a_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [3:0] n;
		n = nib & NIB_MASK;
		if (n < DEC_RADIX) begin
			return CH_ZERO + {4'd0, n};
		end else begin
			return CH_UPA + {4'd0, n - DEC_RADIX};
		end
	endfunction

endpackage

// ----- hw/rtl/n2a_dp.sv -----
module n2a_dp import n2a_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  n2a_cmd_t   cmd,
	output n2a_stat_t  stat,
	input  logic [2:0] op,
	input  logic [63:0] value,
	output logic [7:0] character,
	output logic       last
);

	logic [2:0]  op_q;
	logic [63:0] sr_q;
	logic [39:0] bcd_q;
	logic [5:0]  rem_q;
	logic [4:0]  conv_q;
	logic [1:0]  pfx_q;
	logic [3:0]  grp_q;
	logic [39:0] bcd_adj;
	logic [5:0]  load_len;
	logic [63:0] load_sr;

	always_comb begin
		for (int i = 0; i < 10; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		load_len = 6'd0;
		load_sr  = value;
		case (op)
			OP_DEC32: begin
				load_len = 6'd10;
				load_sr  = {value[31:0], 32'd0};
			end
			OP_HEX32: begin
				load_len = 6'd10;
				load_sr  = {value[31:0], 32'd0};
			end
			OP_HEX64: begin
				load_len = 6'd18;
				load_sr  = value;
			end
			OP_BIN8: begin
				load_len = 6'd8;
				load_sr  = {value[7:0], 56'd0};
			end
			OP_BIN16: begin
				load_len = 6'd17;
				load_sr  = {value[15:0], 48'd0};
			end
			OP_BIN32: begin
				load_len = 6'd35;
				load_sr  = {value[31:0], 32'd0};
			end
			default: begin
				load_len = 6'd0;
				load_sr  = value;
			end
		endcase
	end

	always_comb begin
		stat.in_dec    = (op == OP_DEC32);
		stat.in_valid  = (op <= OP_BIN32);
		stat.conv_last = (conv_q == 5'd0);
		stat.lead_zero = (bcd_q[39:36] == 4'd0) && (rem_q != 6'd1);
		stat.last_char = (rem_q == 6'd1);
	end

	always_comb begin
		character = CH_ZERO;
		case (op_q)
			OP_DEC32: begin
				character = CH_ZERO + {4'd0, bcd_q[39:36]};
			end
			OP_HEX32, OP_HEX64: begin
				if (pfx_q == 2'd2) begin
					character = CH_ZERO;
				end else if (pfx_q == 2'd1) begin
					character = CH_X;
				end else begin
					character = hex_char(sr_q[63:60]);
				end
			end
			OP_BIN8, OP_BIN16, OP_BIN32: begin
				if (grp_q == 4'd8) begin
					character = CH_DOT;
				end else begin
					character = sr_q[63] ? CH_ONE : CH_ZERO;
				end
			end
			default: begin
				character = CH_ZERO;
			end
		endcase
	end

	assign last = stat.last_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_DEC32;
			rem_q  <= 6'd0;
			conv_q <= 5'd0;
			pfx_q  <= 2'd0;
			grp_q  <= 4'd0;
		end else if (cmd.load) begin
			op_q   <= op;
			rem_q  <= load_len;
			conv_q <= 5'd31;
			pfx_q  <= ((op == OP_HEX32) || (op == OP_HEX64)) ? 2'd2 : 2'd0;
			grp_q  <= 4'd0;
		end else if (cmd.conv_step) begin
			conv_q <= conv_q - 5'd1;
		end else if (cmd.skip) begin
			rem_q <= rem_q - 6'd1;
		end else if (cmd.emit) begin
			rem_q <= rem_q - 6'd1;
			if (pfx_q != 2'd0) begin
				pfx_q <= pfx_q - 2'd1;
			end
			if (grp_q == 4'd8) begin
				grp_q <= 4'd0;
			end else begin
				grp_q <= grp_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sr_q  <= load_sr;
			bcd_q <= 40'd0;
		end else if (cmd.conv_step) begin
			sr_q  <= {sr_q[62:0], 1'b0};
			bcd_q <= {bcd_adj[38:0], sr_q[63]};
		end else if (cmd.skip) begin
			bcd_q <= {bcd_q[35:0], 4'd0};
		end else if (cmd.emit) begin
			case (op_q)
				OP_DEC32: begin
					bcd_q <= {bcd_q[35:0], 4'd0};
				end
				OP_HEX32, OP_HEX64: begin
					if (pfx_q == 2'd0) begin
						sr_q <= {sr_q[59:0], 4'd0};
					end
				end
				default: begin
					if (grp_q != 4'd8) begin
						sr_q <= {sr_q[62:0], 1'b0};
					end
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/n2a_ctrl.sv -----
module n2a_ctrl import n2a_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output n2a_cmd_t  cmd,
	input  n2a_stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.skip      = 1'b0;
		cmd.emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.in_dec) begin
						state_d = ST_CONV;
					end else if (stat.in_valid) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (stat.lead_zero) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					cmd.emit = 1'b1;
					if (stat.last_char) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/number_to_ascii_formatter.sv -----
// Hex and binary items show their first character in the cycle after acceptance;
// decimal items first pass through shift-add-3 conversion, then skip each leading
// zero (up to nine), then check the leading digit before the first digit is shown.
// Output runs at one character per cycle while m_tready is high; the block accepts
// no new item until the last character of the current one has been taken.
// One item is in flight at a time.
// Reset (arst_n low) returns the controller to idle at once; no clearing pass is needed.
`include "assert_macros.svh"

module number_to_ascii_formatter import n2a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [2:0]  s_tuser,   // [2:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] character
	output logic        m_tlast
);

	n2a_cmd_t  cmd;
	n2a_stat_t stat;

	n2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	n2a_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (s_tuser),
		.value     (s_tdata),
		.character (m_tdata),
		.last      (m_tlast)
	);

	`ASSERT_CLK(a_one_side, !(s_tready && m_tvalid), "input and output active together")
	`ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready, "no idle after last item")
	`ASSERT_NEXT(a_hex_prefix, s_tvalid && s_tready && (s_tuser == OP_HEX32), m_tvalid && (m_tdata == CH_ZERO), "hex item does not start with zero")

endmodule
